// File: hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted key table
// Action and status codes, sequencer states, field widths of the channels, compare result.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Field widths of the channel payloads
  localparam int ACTION_W  = 3;
  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 3;
  localparam int INDEX_W   = 6;
  localparam int COUNT_W   = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR    = 3'd0,
    ACT_INSERT   = 3'd1,
    ACT_DELETE   = 3'd2,
    ACT_REPLACE  = 3'd3,
    ACT_FIND     = 3'd4,
    ACT_RST_ITER = 3'd5,
    ACT_NEXT     = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_END      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SCMP,
    S_CHK,
    S_SHUP,
    S_SHDN,
    S_NEXT,
    S_FIN
  } state_t;

  // Result of the shared key comparator
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// File: hw/rtl/skt_if.sv
// ----------------------------------------------------------------------------
// skt_if: request and result channels of the sorted key table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface skt_req_if;
  logic                          valid;
  logic                          ready;
  logic [skt_pkg::ACTION_W-1:0]  action;
  logic [skt_pkg::KEY_W-1:0]     key;
  logic [skt_pkg::PAYLOAD_W-1:0] payload;

  modport source (output valid, action, key, payload, input ready);
  modport sink   (input valid, action, key, payload, output ready);
endinterface

interface skt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [skt_pkg::STATUS_W-1:0]  status;
  logic [skt_pkg::INDEX_W-1:0]   index;
  logic [skt_pkg::KEY_W-1:0]     found_key;
  logic [skt_pkg::PAYLOAD_W-1:0] found_payload;
  logic [skt_pkg::COUNT_W-1:0]   count;

  modport source (output valid, status, index, found_key, found_payload, count,
                  input ready);
  modport sink   (input valid, status, index, found_key, found_payload, count,
                  output ready);
endinterface

// File: hw/rtl/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/skt_cmp.sv
// ----------------------------------------------------------------------------
// skt_cmp: shared key comparator
// Unsigned magnitude and equality compare of a stored key against the request.
// ----------------------------------------------------------------------------
module skt_cmp #(
  parameter int W = 32
) (
  input  logic [W-1:0]      stored_key,
  input  logic [W-1:0]      req_key,
  output skt_pkg::cmp_res_t res
);

  assign res.lt = (stored_key < req_key);
  assign res.eq = (stored_key == req_key);

endmodule

// File: hw/rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: ordered key/payload table with binary search
// Up to CAPACITY records kept in ascending key order in one RAM; a sequencer
// runs search, shift and read steps over the shared comparator and RAM port.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat contents                                   | ready
//  ---------+-----+-------------------------------------------------+---------------
//  in_beat  | in  | action, key, payload                            | sequencer idle
//  out_beat | out | status, index, found_key, found_payload, count  | from consumer
//
// Steps per request over the single RAM port and its registered read:
//   clear, reset iterator, unused code, insert when full: result only;
//   next: one RAM read. find/replace/delete-miss: a binary search, each
//     halving step a RAM read in S_SRCH and a compare in S_SCMP, then a
//     check of the position in S_CHK (replace writes there).
//   insert: search, shift up of the records at and above the position (none
//     when appending), then a write of the new record. delete: search, then
//     shift down of the records above it. Worst case: delete of the first record of a full table.
// Reset is synchronous and empties the table; no clearing pass, the RAM is
// only read below the fill count. A stalled result holds in the output
// register; the next request is taken meanwhile and waits at its end.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int CAPACITY     = 64,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  skt_req_if.sink          in_beat,
  skt_rsp_if.source        out_beat
);

  localparam int AW  = $clog2(CAPACITY);      // RAM address
  localparam int CW  = $clog2(CAPACITY + 1);  // counts up to CAPACITY
  localparam int DW  = KEY_BITS + PAYLOAD_BITS;
  localparam int OKW = skt_pkg::KEY_W;
  localparam int OPW = skt_pkg::PAYLOAD_W;
  localparam int OIW = skt_pkg::INDEX_W;
  localparam int OCW = skt_pkg::COUNT_W;

  // Control state
  skt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;          // records held
  logic [CW-1:0]   iter_r, iter_nxt;        // records already read by next
  logic            wr_pend_r, wr_pend_nxt;  // shift write waiting on read data
  logic            out_valid_r, out_valid_nxt;

  // Request and work registers
  skt_pkg::action_t      act_r, act_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [CW-1:0]           lo_r, lo_nxt;    // search window, lo ends as the position
  logic [CW-1:0]           hi_r, hi_nxt;
  logic [CW-1:0]           cur_r, cur_nxt;  // shift cursor
  logic [AW-1:0]           wr_addr_r, wr_addr_nxt;

  // Pending result
  skt_pkg::status_t        res_status_r, res_status_nxt;
  logic [AW-1:0]           res_index_r, res_index_nxt;
  logic [KEY_BITS-1:0]     res_key_r, res_key_nxt;
  logic [PAYLOAD_BITS-1:0] res_pay_r, res_pay_nxt;

  // Output register
  logic [skt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [OIW-1:0]               out_index_r, out_index_nxt;
  logic [OKW-1:0]               out_key_r, out_key_nxt;
  logic [OPW-1:0]               out_pay_r, out_pay_nxt;
  logic [OCW-1:0]               out_count_r, out_count_nxt;

  // RAM and comparator
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [DW-1:0]           mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [DW-1:0]           mem_rdata;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  skt_pkg::cmp_res_t       cmp;

  logic [CW-1:0] mid;
  logic          in_fire;
  logic          out_free;
  logic          full;
  logic          iter_ok;
  skt_pkg::action_t in_act;

  assign in_fire  = in_beat.valid && in_beat.ready;
  assign out_free = !out_valid_r || out_beat.ready;
  assign full     = (cnt_r >= CW'(CAPACITY));
  assign iter_ok  = (iter_r < cnt_r);
  assign in_act   = skt_pkg::action_t'(in_beat.action);
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_key   = mem_rdata[DW-1:PAYLOAD_BITS];
  assign rd_pay   = mem_rdata[PAYLOAD_BITS-1:0];

  skt_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  skt_cmp #(
    .W (KEY_BITS)
  ) u_cmp (
    .stored_key (rd_key),
    .req_key    (key_r),
    .res        (cmp)
  );

  function automatic logic [AW-1:0] cur_nxt_dec(input logic [CW-1:0] c);
    logic [CW-1:0] d;
    d = c - 1'b1;
    return d[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] cur_nxt_inc(input logic [CW-1:0] c);
    logic [CW-1:0] d;
    d = c + 1'b1;
    return d[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skt_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_act)
            skt_pkg::ACT_INSERT:  state_nxt = full ? skt_pkg::S_FIN : skt_pkg::S_SRCH;
            skt_pkg::ACT_DELETE,
            skt_pkg::ACT_REPLACE,
            skt_pkg::ACT_FIND:    state_nxt = skt_pkg::S_SRCH;
            skt_pkg::ACT_NEXT:    state_nxt = iter_ok ? skt_pkg::S_NEXT : skt_pkg::S_FIN;
            default:              state_nxt = skt_pkg::S_FIN;
          endcase
        end
      end
      skt_pkg::S_SRCH: begin
        if (lo_r < hi_r) begin
          state_nxt = skt_pkg::S_SCMP;
        end else if (lo_r < cnt_r) begin
          state_nxt = skt_pkg::S_CHK;
        end else if (act_r == skt_pkg::ACT_INSERT) begin
          state_nxt = skt_pkg::S_SHUP;
        end else begin
          state_nxt = skt_pkg::S_FIN;
        end
      end
      skt_pkg::S_SCMP: state_nxt = skt_pkg::S_SRCH;
      skt_pkg::S_CHK: begin
        if (cmp.eq && act_r == skt_pkg::ACT_DELETE) begin
          state_nxt = skt_pkg::S_SHDN;
        end else if (!cmp.eq && act_r == skt_pkg::ACT_INSERT) begin
          state_nxt = skt_pkg::S_SHUP;
        end else begin
          state_nxt = skt_pkg::S_FIN;
        end
      end
      skt_pkg::S_SHUP: begin
        if (!(cur_r > lo_r) && !wr_pend_r) begin
          state_nxt = skt_pkg::S_FIN;
        end
      end
      skt_pkg::S_SHDN: begin
        if (!((cur_r + 1'b1) < cnt_r) && !wr_pend_r) begin
          state_nxt = skt_pkg::S_FIN;
        end
      end
      skt_pkg::S_NEXT: state_nxt = skt_pkg::S_FIN;
      skt_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = skt_pkg::S_IDLE;
        end
      end
      default: state_nxt = skt_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    cnt_nxt        = cnt_r;
    iter_nxt       = iter_r;
    wr_pend_nxt    = wr_pend_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    cur_nxt        = cur_r;
    wr_addr_nxt    = wr_addr_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = '0;

    if (out_valid_r && out_beat.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      skt_pkg::S_IDLE: begin
        if (in_fire) begin
          act_nxt        = in_act;
          key_nxt        = KEY_BITS'(in_beat.key);
          pay_nxt        = PAYLOAD_BITS'(in_beat.payload);
          lo_nxt         = '0;
          hi_nxt         = cnt_r;
          wr_pend_nxt    = 1'b0;
          res_status_nxt = skt_pkg::ST_OK;
          res_index_nxt  = '0;
          res_key_nxt    = '0;
          res_pay_nxt    = '0;
          case (in_act)
            skt_pkg::ACT_CLEAR: begin
              cnt_nxt  = '0;
              iter_nxt = '0;
            end
            skt_pkg::ACT_INSERT: begin
              if (full) begin
                res_status_nxt = skt_pkg::ST_FULL;
              end
            end
            skt_pkg::ACT_RST_ITER: iter_nxt = '0;
            skt_pkg::ACT_NEXT: begin
              if (iter_ok) begin
                mem_raddr = iter_r[AW-1:0];
              end else begin
                res_status_nxt = skt_pkg::ST_END;
              end
            end
            default: ;
          endcase
        end
      end
      skt_pkg::S_SRCH: begin
        if (lo_r < hi_r) begin
          mem_raddr = mid[AW-1:0];
        end else if (lo_r < cnt_r) begin
          mem_raddr = lo_r[AW-1:0];
        end else if (act_r == skt_pkg::ACT_INSERT) begin
          cur_nxt = cnt_r;     // append at the end
        end else begin
          res_status_nxt = skt_pkg::ST_NOTFOUND;
        end
      end
      skt_pkg::S_SCMP: begin
        if (cmp.lt) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
      end
      skt_pkg::S_CHK: begin
        if (cmp.eq) begin
          case (act_r)
            skt_pkg::ACT_INSERT: begin
              res_status_nxt = skt_pkg::ST_DUP;
              res_index_nxt  = lo_r[AW-1:0];
            end
            skt_pkg::ACT_DELETE: cur_nxt = lo_r;
            skt_pkg::ACT_REPLACE: begin
              mem_we        = 1'b1;
              mem_waddr     = lo_r[AW-1:0];
              mem_wdata     = {key_r, pay_r};
              res_index_nxt = lo_r[AW-1:0];
            end
            skt_pkg::ACT_FIND: begin
              res_index_nxt = lo_r[AW-1:0];
              res_key_nxt   = rd_key;
              res_pay_nxt   = rd_pay;
            end
            default: ;
          endcase
        end else if (act_r == skt_pkg::ACT_INSERT) begin
          cur_nxt = cnt_r;
        end else begin
          res_status_nxt = skt_pkg::ST_NOTFOUND;
        end
      end
      skt_pkg::S_SHUP: begin
        // read entry cur-1 now, write it to cur on the next cycle
        if (wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r;
          mem_wdata = mem_rdata;
        end
        if (cur_r > lo_r) begin
          mem_raddr   = cur_nxt_dec(cur_r);
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = cur_r[AW-1:0];
          cur_nxt     = cur_r - 1'b1;
        end else if (wr_pend_r) begin
          wr_pend_nxt = 1'b0;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = lo_r[AW-1:0];
          mem_wdata     = {key_r, pay_r};
          cnt_nxt       = cnt_r + 1'b1;
          res_index_nxt = lo_r[AW-1:0];
        end
      end
      skt_pkg::S_SHDN: begin
        // read entry cur+1 now, write it to cur on the next cycle
        if (wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r;
          mem_wdata = mem_rdata;
        end
        if ((cur_r + 1'b1) < cnt_r) begin
          mem_raddr   = cur_nxt_inc(cur_r);
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = cur_r[AW-1:0];
          cur_nxt     = cur_r + 1'b1;
        end else if (wr_pend_r) begin
          wr_pend_nxt = 1'b0;
        end else begin
          cnt_nxt       = cnt_r - 1'b1;
          res_index_nxt = lo_r[AW-1:0];
        end
      end
      skt_pkg::S_NEXT: begin
        res_index_nxt = iter_r[AW-1:0];
        res_key_nxt   = rd_key;
        res_pay_nxt   = rd_pay;
        iter_nxt      = iter_r + 1'b1;
      end
      skt_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = OIW'(res_index_r);
          out_key_nxt    = OKW'(res_key_r);
          out_pay_nxt    = OPW'(res_pay_r);
          out_count_nxt  = OCW'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::S_IDLE;
      cnt_r       <= '0;
      iter_r      <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iter_r      <= iter_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    cur_r        <= cur_nxt;
    wr_addr_r    <= wr_addr_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Ports
  assign in_beat.ready          = (state_r == skt_pkg::S_IDLE);
  assign out_beat.valid         = out_valid_r;
  assign out_beat.status        = out_status_r;
  assign out_beat.index         = out_index_r;
  assign out_beat.found_key     = out_key_r;
  assign out_beat.found_payload = out_pay_r;
  assign out_beat.count         = out_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("record count above capacity");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == skt_pkg::S_CHK || state_r == skt_pkg::S_SHUP ||
                state_r == skt_pkg::S_SHDN))
    else $error("RAM write outside replace or shift");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skt_pkg::S_SCMP |-> (lo_r < hi_r) && (hi_r <= cnt_r))
    else $error("binary search window broken");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == skt_pkg::ST_FULL) |-> out_count_r == OCW'(CAPACITY))
    else $error("full status with table not full");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skt_pkg::S_SHUP && state_nxt == skt_pkg::S_FIN) |=>
      cnt_r == $past(cnt_r) + 1'b1)
    else $error("insert did not grow the table");

endmodule
